### hw/rtl/tnpg_pkg.sv
// Package for the turbulence noise pixel generator.
// Holds table geometry, arithmetic widths, codes, the sequencer state type
// and the divider request/response structs. No dependencies.
package tnpg_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int NOISE_BITS = 16;
  localparam int MAX_SIZE   = 256;

  localparam int TBL_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  // Divider: dividend is a coordinate of up to 10 bits shifted by up to 25.
  localparam int DIV_NW = 35;
  localparam int DIV_VW = 10;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SIZE   = 2'd2;
  localparam logic [1:0] REG_ALPHA  = 2'd3;

  // Input commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Channel numbers.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHAN,
    ST_DIVX,
    ST_MODX,
    ST_DIVY,
    ST_MODY,
    ST_ADDR,
    ST_DATA,
    ST_MAC,
    ST_ACC,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DIV_NW-1:0]   dividend;
    logic [DIV_VW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_NW-1:0]   quot;
    logic [DIV_VW-1:0]   rem;
  } div_rsp_t;

endpackage

### hw/rtl/tnpg_ifs.sv
// Channel interfaces of the turbulence noise pixel generator.
// Depends on nothing; widths follow the fixed word formats.
interface tnpg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] noise_index;
  logic [15:0] noise_value;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  modport source(output valid, command, noise_index, noise_value, pixel_x, pixel_y,
                 input ready);
  modport sink(input valid, command, noise_index, noise_value, pixel_x, pixel_y,
               output ready);
endinterface

interface tnpg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha;
  modport source(output valid, red, green, blue, alpha, input ready);
  modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

interface tnpg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/turbulence_noise_pixel_generator_unit.sv
// Top level of the turbulence noise pixel generator.
// Depends on tnpg_pkg, tnpg_ifs, tnpg_ram and tnpg_div.
//
// The block holds a 65536-entry noise table of 16-bit fractions in one RAM.
// A load word (command 0) writes one entry in the cycle it is accepted and
// gives no result. A compute word (command 1) produces one result word with
// red, green, blue and alpha, each a saturated Q0.16 turbulence value. The
// table contents are undefined after reset, so every entry a pixel touches
// must have been loaded first. A channel with starting size S runs
// floor(log2 S)+1 octaves. The cost of a compute word is set by the shared
// bit-serial divider, which runs four 35-step passes per octave (x position,
// x wrap, y position, y wrap), and by the single table read port, which
// fetches the four neighbors one at a time. The block accepts the next word
// while a finished result still waits on the output register. Configuration
// writes are taken in any cycle and must only be issued while the block is
// idle.
module turbulence_noise_pixel_generator_unit (
  input  logic             clk,
  input  logic             rst_n,
  tnpg_in_if.sink          in_if,
  tnpg_out_if.source       out_if,
  tnpg_cfg_if.sink         cfg_if
);

  // Configuration registers.
  logic [8:0] width_r, height_r, size_r;
  logic       alpha_mode_r;

  // Effective geometry after clamping.
  logic [8:0] w_eff, h_eff, s_eff;

  // Sequencer.
  tnpg_pkg::state_t state_r, state_nxt;
  logic [1:0]  ch_r;
  logic [3:0]  k_r;
  logic        dsent_r;
  logic [7:0]  px_r;
  logic [7:0]  py_r;
  logic [9:0]  cy_r;
  logic [9:0]  csize_r;
  logic [1:0]  nb_r;

  // Sample position and wrapped neighbor coordinates.
  logic [tnpg_pkg::DIV_NW-17:0] ip_r;
  logic [15:0] fx_r, fy_r;
  logic [8:0]  xa_r, xb_r, ya_r, yb_r;

  // Arithmetic.
  logic [33:0] wxy_r;
  logic [49:0] prod_r;
  logic [49:0] samp_r;
  logic [49:0] acc_r;
  logic [15:0] red_r, green_r, blue_r, alpha_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;

  // Combinational helpers.
  logic        in_fire;
  logic        in_ready_c;
  logic        div_st;
  logic        octave_more;
  logic [9:0]  ch_size;
  logic [9:0]  ch_cy;
  logic [16:0] wx, wy;
  logic [8:0]  row, col;
  logic [17:0] row_base;
  logic [tnpg_pkg::TBL_AW-1:0] raddr;
  logic [15:0] rdata;
  logic [15:0] sat_val;
  logic [4:0]  shamt;
  logic        ram_we;

  tnpg_pkg::div_req_t div_req;
  tnpg_pkg::div_rsp_t div_rsp;

  // Zero width or height is treated as one; size is saturated.
  always_comb begin
    w_eff = (width_r == 9'd0) ? 9'd1 :
            (width_r > 9'(tnpg_pkg::MAX_WIDTH)) ? 9'(tnpg_pkg::MAX_WIDTH) : width_r;
    h_eff = (height_r == 9'd0) ? 9'd1 :
            (height_r > 9'(tnpg_pkg::MAX_HEIGHT)) ? 9'(tnpg_pkg::MAX_HEIGHT) : height_r;
    s_eff = (size_r > 9'(tnpg_pkg::MAX_SIZE)) ? 9'(tnpg_pkg::MAX_SIZE) : size_r;
  end

  // Configuration writes are always accepted.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= 9'd256;
      height_r     <= 9'd256;
      size_r       <= 9'd64;
      alpha_mode_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        tnpg_pkg::REG_WIDTH:  width_r      <= cfg_if.data;
        tnpg_pkg::REG_HEIGHT: height_r     <= cfg_if.data;
        tnpg_pkg::REG_SIZE:   size_r       <= cfg_if.data;
        tnpg_pkg::REG_ALPHA:  alpha_mode_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // Per-channel starting size and y coordinate. Green and blue use half the
  // size, alpha twice the size at the mirrored row, saturated at zero.
  always_comb begin
    case (ch_r)
      tnpg_pkg::CH_RED: begin
        ch_size = {1'b0, s_eff};
        ch_cy   = {2'b00, py_r};
      end
      tnpg_pkg::CH_GREEN: begin
        ch_size = {2'b00, s_eff[8:1]};
        ch_cy   = {2'b00, py_r} + {1'b0, h_eff};
      end
      tnpg_pkg::CH_BLUE: begin
        ch_size = {2'b00, s_eff[8:1]};
        ch_cy   = {2'b00, py_r} + {h_eff, 1'b0};
      end
      default: begin
        ch_size = {s_eff, 1'b0};
        ch_cy   = ({1'b0, py_r} <= h_eff) ? ({1'b0, h_eff} - {2'b00, py_r}) : 10'd0;
      end
    endcase
  end

  // Another octave follows while 2^(k+1) is not above the size.
  assign octave_more = (11'd1 << ({1'b0, k_r} + 5'd1)) <= {1'b0, csize_r};
  assign shamt       = {1'b0, k_r} + 5'd1;

  // Neighbor selection: bit 0 picks column b with weight 1-fx, bit 1 picks
  // row b with weight 1-fy.
  always_comb begin
    wx       = nb_r[0] ? (17'h10000 - {1'b0, fx_r}) : {1'b0, fx_r};
    wy       = nb_r[1] ? (17'h10000 - {1'b0, fy_r}) : {1'b0, fy_r};
    col      = nb_r[0] ? xb_r : xa_r;
    row      = nb_r[1] ? yb_r : ya_r;
    row_base = row * w_eff;
    raddr    = tnpg_pkg::TBL_AW'(row_base + {9'd0, col});
  end

  assign sat_val = (acc_r[49:48] != 2'b00) ? 16'hFFFF : acc_r[47:32];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tnpg_pkg::ST_IDLE:
        if (in_fire && in_if.command == tnpg_pkg::CMD_COMPUTE) begin
          state_nxt = tnpg_pkg::ST_CHAN;
        end
      tnpg_pkg::ST_CHAN:
        if (ch_size == 10'd0 || (ch_r == tnpg_pkg::CH_ALPHA && !alpha_mode_r)) begin
          state_nxt = tnpg_pkg::ST_NEXT;
        end else begin
          state_nxt = tnpg_pkg::ST_DIVX;
        end
      tnpg_pkg::ST_DIVX: if (div_rsp.done) state_nxt = tnpg_pkg::ST_MODX;
      tnpg_pkg::ST_MODX: if (div_rsp.done) state_nxt = tnpg_pkg::ST_DIVY;
      tnpg_pkg::ST_DIVY: if (div_rsp.done) state_nxt = tnpg_pkg::ST_MODY;
      tnpg_pkg::ST_MODY: if (div_rsp.done) state_nxt = tnpg_pkg::ST_ADDR;
      tnpg_pkg::ST_ADDR: state_nxt = tnpg_pkg::ST_DATA;
      tnpg_pkg::ST_DATA: state_nxt = tnpg_pkg::ST_MAC;
      tnpg_pkg::ST_MAC:
        state_nxt = (nb_r == 2'd3) ? tnpg_pkg::ST_ACC : tnpg_pkg::ST_ADDR;
      tnpg_pkg::ST_ACC:
        state_nxt = octave_more ? tnpg_pkg::ST_DIVX : tnpg_pkg::ST_NEXT;
      tnpg_pkg::ST_NEXT:
        state_nxt = (ch_r == tnpg_pkg::CH_ALPHA) ? tnpg_pkg::ST_OUT : tnpg_pkg::ST_CHAN;
      tnpg_pkg::ST_OUT:
        if (!out_valid_r || out_if.ready) begin
          state_nxt = tnpg_pkg::ST_IDLE;
        end
      default: state_nxt = tnpg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM write and divider request.
  always_comb begin
    in_ready_c  = (state_r == tnpg_pkg::ST_IDLE);
    div_st      = state_r inside {tnpg_pkg::ST_DIVX, tnpg_pkg::ST_MODX,
                                  tnpg_pkg::ST_DIVY, tnpg_pkg::ST_MODY};
    div_req.start = div_st && !dsent_r;
    case (state_r)
      tnpg_pkg::ST_DIVX: begin
        div_req.dividend = {{(tnpg_pkg::DIV_NW-8){1'b0}}, px_r} << ({1'b0, k_r} + 5'd16);
        div_req.divisor  = csize_r;
      end
      tnpg_pkg::ST_DIVY: begin
        div_req.dividend = {{(tnpg_pkg::DIV_NW-10){1'b0}}, cy_r} << ({1'b0, k_r} + 5'd16);
        div_req.divisor  = csize_r;
      end
      tnpg_pkg::ST_MODX: begin
        div_req.dividend = {16'd0, ip_r};
        div_req.divisor  = {1'b0, w_eff};
      end
      default: begin
        div_req.dividend = {16'd0, ip_r};
        div_req.divisor  = {1'b0, h_eff};
      end
    endcase
  end

  assign in_if.ready = in_ready_c;
  assign in_fire     = in_if.valid && in_ready_c;
  assign ram_we      = in_fire && in_if.command == tnpg_pkg::CMD_LOAD;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tnpg_pkg::ST_IDLE;
      dsent_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ch_r        <= tnpg_pkg::CH_RED;
      k_r         <= '0;
      nb_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tnpg_pkg::ST_OUT && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (div_req.start) begin
        dsent_r <= 1'b1;
      end else if (div_rsp.done) begin
        dsent_r <= 1'b0;
      end
      case (state_r)
        tnpg_pkg::ST_IDLE:
          if (in_fire) begin
            px_r <= in_if.pixel_x;
            py_r <= in_if.pixel_y;
            ch_r <= tnpg_pkg::CH_RED;
          end
        tnpg_pkg::ST_CHAN: begin
          cy_r    <= ch_cy;
          csize_r <= ch_size;
          k_r     <= '0;
          nb_r    <= '0;
          samp_r  <= '0;
          // Alpha in mode zero is constant one, shown as 65535.
          acc_r   <= (ch_r == tnpg_pkg::CH_ALPHA && !alpha_mode_r) ?
                     {2'b00, 16'hFFFF, 32'd0} : '0;
        end
        tnpg_pkg::ST_DIVX:
          if (div_rsp.done) begin
            fx_r <= div_rsp.quot[15:0];
            ip_r <= div_rsp.quot[tnpg_pkg::DIV_NW-1:16];
          end
        tnpg_pkg::ST_MODX:
          if (div_rsp.done) begin
            xa_r <= div_rsp.rem[8:0];
            xb_r <= (div_rsp.rem == '0) ? (w_eff - 9'd1) : (div_rsp.rem[8:0] - 9'd1);
          end
        tnpg_pkg::ST_DIVY:
          if (div_rsp.done) begin
            fy_r <= div_rsp.quot[15:0];
            ip_r <= div_rsp.quot[tnpg_pkg::DIV_NW-1:16];
          end
        tnpg_pkg::ST_MODY:
          if (div_rsp.done) begin
            ya_r <= div_rsp.rem[8:0];
            yb_r <= (div_rsp.rem == '0) ? (h_eff - 9'd1) : (div_rsp.rem[8:0] - 9'd1);
          end
        tnpg_pkg::ST_ADDR: wxy_r <= wx * wy;
        tnpg_pkg::ST_DATA: prod_r <= wxy_r * rdata;
        tnpg_pkg::ST_MAC: begin
          samp_r <= samp_r + prod_r;
          nb_r   <= nb_r + 2'd1;
        end
        tnpg_pkg::ST_ACC: begin
          // Term k carries weight 2^-(k+1) and is truncated before the sum.
          acc_r  <= acc_r + (samp_r >> shamt);
          samp_r <= '0;
          k_r    <= k_r + 4'd1;
        end
        tnpg_pkg::ST_NEXT: begin
          case (ch_r)
            tnpg_pkg::CH_RED:   red_r   <= sat_val;
            tnpg_pkg::CH_GREEN: green_r <= sat_val;
            tnpg_pkg::CH_BLUE:  blue_r  <= sat_val;
            default: begin
              alpha_r <= sat_val;
            end
          endcase
          ch_r <= ch_r + 2'd1;
        end
        tnpg_pkg::ST_OUT:
          // The output fields load only once a held result has left, so a
          // stalled result never changes.
          if (!out_valid_r || out_if.ready) begin
            out_red_r   <= red_r;
            out_green_r <= green_r;
            out_blue_r  <= blue_r;
            out_alpha_r <= alpha_r;
          end
        default: ;
      endcase
    end
  end

  tnpg_ram #(
    .WIDTH(tnpg_pkg::NOISE_BITS),
    .DEPTH(tnpg_pkg::TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_if.noise_index[tnpg_pkg::TBL_AW-1:0]),
    .wdata (in_if.noise_value[tnpg_pkg::NOISE_BITS-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  tnpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_if.valid = out_valid_r;
  assign out_if.red   = out_red_r;
  assign out_if.green = out_green_r;
  assign out_if.blue  = out_blue_r;
  assign out_if.alpha = out_alpha_r;

endmodule

### hw/rtl/tnpg_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module tnpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tnpg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tnpg_pkg for widths and the request/response structs.
module tnpg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tnpg_pkg::div_req_t  req,
  output tnpg_pkg::div_rsp_t  rsp
);

  logic [tnpg_pkg::DIV_NW-1:0] q_r;
  logic [tnpg_pkg::DIV_VW-1:0] rem_r;
  logic [tnpg_pkg::DIV_VW-1:0] d_r;
  logic [tnpg_pkg::DIV_CW-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tnpg_pkg::DIV_VW:0]   shifted;
  logic                        ge;
  logic [tnpg_pkg::DIV_VW:0]   diff;

  always_comb begin
    shifted = {rem_r, q_r[tnpg_pkg::DIV_NW-1]};
    ge      = shifted >= {1'b0, d_r};
    diff    = shifted - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= tnpg_pkg::DIV_CW'(tnpg_pkg::DIV_NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[tnpg_pkg::DIV_NW-2:0], ge};
        rem_r <= ge ? diff[tnpg_pkg::DIV_VW-1:0] : shifted[tnpg_pkg::DIV_VW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tnpg_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

### hw/rtl/tnpg_checker.sv
// Port-level checker for the turbulence noise pixel generator, with bind.
// Depends on the top level's interface ports only.
module tnpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic        cfg_ready
);

  // A held result stays valid and keeps its red field.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red))
    else $error("result changed while stalled");

  // A compute word makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !in_ready)
    else $error("block took a word while computing");

  // A new result only appears after a busy cycle.
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without computation");

  // The configuration port never stalls.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind turbulence_noise_pixel_generator_unit tnpg_checker u_tnpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_command (in_if.command),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_red    (out_if.red),
  .cfg_ready  (cfg_if.ready)
);
